@@ hw/rtl/lpfd_pkg.sv @@
// Shared types and constants for the length-prefixed frame decoder.
package lpfd_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned LEN_BYTES    = HEADER_BYTES - 1;
    localparam int unsigned CNT_W        = 3;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PAYLOAD  = 2'd0;
    localparam t_kind KIND_EMPTY    = 2'd1;
    localparam t_kind KIND_BAD_TYPE = 2'd2;
    localparam t_kind KIND_TOO_LONG = 2'd3;

    typedef enum logic [1:0] {
        CFG_MAX_FRAME_LEN = 2'd0,
        CFG_JSON_TYPE     = 2'd1,
        CFG_BINARY_TYPE   = 2'd2
    } t_cfg_index;

    localparam logic [31:0] MAX_FRAME_LEN_RST = 32'd16777216;
    localparam logic [7:0]  JSON_TYPE_RST     = 8'd1;
    localparam logic [7:0]  BINARY_TYPE_RST   = 8'd2;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic        frame_kind;
        logic        last;
    } t_result;

endpackage

@@ hw/rtl/lpfd_parse.sv @@
// Header collection, type and length check, payload pass-through.
module lpfd_parse
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_max_frame_len,
    input  logic [7:0]  i_json_type_code,
    input  logic [7:0]  i_binary_type_code,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic              r_in_payload;
    logic [CNT_W-1:0]  r_hdr_cnt;
    logic [31:0]       r_len_acc;
    logic [31:0]       r_bytes_left;
    logic              r_cur_kind;

    logic              n_in_payload;
    logic [CNT_W-1:0]  n_hdr_cnt;
    logic [31:0]       n_len_acc;
    logic [31:0]       n_bytes_left;
    logic              n_cur_kind;

    logic              is_last;

    assign is_last = (r_bytes_left <= 32'd1);

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_len_acc    = r_len_acc;
        n_bytes_left = r_bytes_left;
        n_cur_kind   = r_cur_kind;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (r_in_payload) begin
            o_res_valid        = 1'b1;
            o_res.kind         = KIND_PAYLOAD;
            o_res.payload_byte = i_data_byte;
            o_res.frame_kind   = r_cur_kind;
            o_res.last         = is_last;
            if (is_last) begin
                n_in_payload = 1'b0;
                n_hdr_cnt    = '0;
                n_len_acc    = '0;
                n_bytes_left = '0;
            end else begin
                n_bytes_left = r_bytes_left - 32'd1;
            end
        end else if (r_hdr_cnt < CNT_W'(LEN_BYTES)) begin
            n_len_acc = {r_len_acc[23:0], i_data_byte};
            n_hdr_cnt = r_hdr_cnt + CNT_W'(1);
        end else begin
            // type byte: header complete, restart collection unless a payload follows
            n_hdr_cnt    = '0;
            n_len_acc    = '0;
            n_bytes_left = '0;
            o_res_valid  = 1'b1;
            if (i_data_byte != i_json_type_code && i_data_byte != i_binary_type_code) begin
                o_res.kind = KIND_BAD_TYPE;
            end else if (r_len_acc > i_max_frame_len) begin
                o_res.kind = KIND_TOO_LONG;
            end else begin
                // json code wins when both codes are equal
                n_cur_kind = (i_data_byte != i_json_type_code);
                if (r_len_acc == 32'd0) begin
                    o_res.kind       = KIND_EMPTY;
                    o_res.frame_kind = n_cur_kind;
                    o_res.last       = 1'b1;
                end else begin
                    o_res_valid  = 1'b0;
                    n_in_payload = 1'b1;
                    n_bytes_left = r_len_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_len_acc    <= '0;
            r_bytes_left <= '0;
            r_cur_kind   <= 1'b0;
        end else if (i_accept) begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_len_acc    <= n_len_acc;
            r_bytes_left <= n_bytes_left;
            r_cur_kind   <= n_cur_kind;
        end
    end

endmodule

@@ hw/rtl/length_prefixed_frame_decoder_core.sv @@
// A result is registered into the output register, or into the skid when the output is held.
// Throughput: one byte per cycle while the skid is empty; the parse logic is a single registered pass per byte.
// A two-entry output (register plus skid) lets input continue while a result waits.
// Input stall is the registered skid-full flag, so it never depends on the output stall.
// Synchronous active-low reset clears frame state, output valids and restores register defaults.
module length_prefixed_frame_decoder_core
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_kind,
    output logic        o_last
);

    logic [31:0] r_max_frame_len;
    logic [7:0]  r_json_type_code;
    logic [7:0]  r_binary_type_code;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_accept;
    logic        out_pop;
    logic        res_valid;
    t_result     res;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_pop    = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_len    <= MAX_FRAME_LEN_RST;
            r_json_type_code   <= JSON_TYPE_RST;
            r_binary_type_code <= BINARY_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_FRAME_LEN: r_max_frame_len    <= i_cfg_data;
                CFG_JSON_TYPE:     r_json_type_code   <= i_cfg_data[7:0];
                CFG_BINARY_TYPE:   r_binary_type_code <= i_cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    lpfd_parse u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_data_byte        (i_data_byte),
        .i_max_frame_len    (r_max_frame_len),
        .i_json_type_code   (r_json_type_code),
        .i_binary_type_code (r_binary_type_code),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled here, so no new result arrives
            if (out_pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept && res_valid) begin
            if (!r_out_valid || out_pop) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_kind   = r_out.frame_kind;
    assign o_last         = r_out.last;

endmodule
